[hdl/pcb_pkg.sv]
package pcb_pkg;

   localparam int MAX_CELLS      = 1024;
   localparam int SLOTS_PER_CELL = 64;
   localparam int CELL_W         = 10;
   localparam int SLOT_W         = 6;
   localparam int COUNT_W        = 7;
   localparam int NUM_CELLS_W    = 11;
   localparam int COORD_W        = 32;
   localparam int ID_W           = 24;
   localparam int ENTRY_ADDR_W   = CELL_W + SLOT_W;
   localparam int ENTRY_W        = 4 * COORD_W + ID_W;
   localparam int CSR_ADDR_W     = 4;

   // request operations
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OUT_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   // register indexes
   localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
   localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
   localparam logic [1:0] REG_CELL_SCALE = 2'd2;
   localparam logic [1:0] REG_NUM_CELLS  = 2'd3;

   typedef enum logic [2:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_CALC,
      SEQ_LOOKUP,
      SEQ_DONE
   } pcb_state_type;

   typedef struct packed {
      logic              in_range;
      logic [CELL_W-1:0] cell_idx;
   } pcb_calc_res_type;

endpackage

[hdl/pcb_ram.sv]
module pcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pcb_cell_calc.sv]
module pcb_cell_calc
   import pcb_pkg::*;
(
   input  logic                   clock,
   input  logic                   step,
   input  logic [COORD_W-1:0]     sort_coord,
   input  logic [COORD_W-1:0]     range_low,
   input  logic [COORD_W-1:0]     range_high,
   input  logic [COORD_W-1:0]     cell_scale,
   input  logic [NUM_CELLS_W-1:0] num_cells,
   output pcb_calc_res_type       res
);

   logic [2*COORD_W-1:0]   prod_ff, prod_in;
   logic                   in_range_ff, in_range_in;
   logic [COORD_W-1:0]     diff;
   logic [NUM_CELLS_W-1:0] n_eff;
   logic [NUM_CELLS_W-1:0] last;
   logic [24:0]            raw_cell;

   // stage 1: range check and Q8.23 x Q16.16 product
   // in range the offset is below 2^32, so the 32-bit wrap is exact
   always_comb begin
      diff        = sort_coord - range_low;
      in_range_in = ($signed(sort_coord) >= $signed(range_low)) &&
                    ($signed(sort_coord) <  $signed(range_high));
      prod_in     = {{COORD_W{1'b0}}, diff} * {{COORD_W{1'b0}}, cell_scale};
   end

   always_ff @(posedge clock) begin
      if (step) begin
         prod_ff     <= prod_in;
         in_range_ff <= in_range_in;
      end
   end

   // stage 2: drop 39 fraction bits, saturate to last cell in use
   always_comb begin
      if (num_cells == '0) begin
         n_eff = NUM_CELLS_W'(1);
      end else if (num_cells > NUM_CELLS_W'(MAX_CELLS)) begin
         n_eff = NUM_CELLS_W'(MAX_CELLS);
      end else begin
         n_eff = num_cells;
      end
      last     = n_eff - NUM_CELLS_W'(1);
      raw_cell = prod_ff[2*COORD_W-1:39];
      res.in_range = in_range_ff;
      if (raw_cell > {14'd0, last}) begin
         res.cell_idx = last[CELL_W-1:0];
      end else begin
         res.cell_idx = raw_cell[CELL_W-1:0];
      end
   end

endmodule

[hdl/particle_cell_binning_1d_top.sv]
// 1-D particle cell binning. Each request is an insert, a read or a clear and
// gives exactly one response. An insert in [range_low, range_high) lands in
// cell floor((sort_coord - range_low) * cell_scale), saturated to the last
// cell in use, and is appended at that cell's next slot (64 slots per cell);
// a full cell drops it with status 2. Insert and read run through CALC
// (32x32 multiply), LOOKUP (count memory read) and DONE (decide and write
// back, held while the response register is full and not draining). A new
// request is taken once the previous one has moved into the response
// register. A clear, and every reset, sweeps all 1024 count memory entries
// to zero; no request is taken during it, CSR writes are.
// Entry records live in a 65536 x 152 memory that is never cleared: only
// slots below a cell's count are ever returned.
module particle_cell_binning_1d_top
   import pcb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [COORD_W-1:0]    req_coord_x,
   input  logic [COORD_W-1:0]    req_coord_y,
   input  logic [COORD_W-1:0]    req_coord_z,
   input  logic [COORD_W-1:0]    req_sort_coord,
   input  logic [ID_W-1:0]       req_particle_id,
   input  logic [CELL_W-1:0]     req_read_cell,
   input  logic [SLOT_W-1:0]     req_read_slot,

   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [CELL_W-1:0]     rsp_cell_res,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic [COUNT_W-1:0]    rsp_cell_count,
   output logic [COORD_W-1:0]    rsp_out_x,
   output logic [COORD_W-1:0]    rsp_out_y,
   output logic [COORD_W-1:0]    rsp_out_z,
   output logic [COORD_W-1:0]    rsp_out_coord,
   output logic [ID_W-1:0]       rsp_out_id,

   // APB-style CSR port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // ---------------- CSRs ----------------
   logic [COORD_W-1:0]     range_low_ff, range_high_ff, cell_scale_ff;
   logic [NUM_CELLS_W-1:0] num_cells_ff;
   logic                   csr_wr;
   logic [1:0]             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= '0;
         cell_scale_ff <= '0;
         num_cells_ff  <= NUM_CELLS_W'(MAX_CELLS);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_RANGE_LOW:  range_low_ff  <= csr_pwdata;
            REG_RANGE_HIGH: range_high_ff <= csr_pwdata;
            REG_CELL_SCALE: cell_scale_ff <= csr_pwdata;
            REG_NUM_CELLS:  num_cells_ff  <= csr_pwdata[NUM_CELLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_RANGE_LOW:  csr_prdata = range_low_ff;
         REG_RANGE_HIGH: csr_prdata = range_high_ff;
         REG_CELL_SCALE: csr_prdata = cell_scale_ff;
         REG_NUM_CELLS:  csr_prdata = {21'd0, num_cells_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------- request capture ----------------
   logic [1:0]         op_ff;
   logic [COORD_W-1:0] x_ff, y_ff, z_ff, sc_ff;
   logic [ID_W-1:0]    id_ff;
   logic [CELL_W-1:0]  rd_cell_ff;
   logic [SLOT_W-1:0]  rd_slot_ff;
   logic               req_fire;

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff      <= req_op;
         x_ff       <= req_coord_x;
         y_ff       <= req_coord_y;
         z_ff       <= req_coord_z;
         sc_ff      <= req_sort_coord;
         id_ff      <= req_particle_id;
         rd_cell_ff <= req_read_cell;
         rd_slot_ff <= req_read_slot;
      end
   end

   // ---------------- cell index ----------------
   pcb_calc_res_type calc_res;
   logic             calc_step;

   pcb_cell_calc u_calc (
      .clock      (clock),
      .step       (calc_step),
      .sort_coord (sc_ff),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .cell_scale (cell_scale_ff),
      .num_cells  (num_cells_ff),
      .res        (calc_res)
   );

   // ---------------- memories ----------------
   logic                    fill_wr_en, fill_rd_en;
   logic [CELL_W-1:0]       fill_wr_addr, fill_rd_addr;
   logic [COUNT_W-1:0]      fill_wr_data, fill_rd_data;
   logic                    ent_wr_en, ent_rd_en;
   logic [ENTRY_ADDR_W-1:0] ent_wr_addr, ent_rd_addr;
   logic [ENTRY_W-1:0]      ent_wr_data, ent_rd_data;

   pcb_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_CELLS)) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (fill_wr_addr),
      .wr_data (fill_wr_data),
      .rd_en   (fill_rd_en),
      .rd_addr (fill_rd_addr),
      .rd_data (fill_rd_data)
   );

   pcb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CELLS * SLOTS_PER_CELL)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   // ---------------- sequencer ----------------
   pcb_state_type     state_ff, state_in;
   logic [CELL_W-1:0] clr_idx_ff, clr_idx_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              done_fire;
   logic              sweep_last;

   // response may load when the output register is empty or draining
   assign done_fire  = (state_ff == SEQ_DONE) && (!rsp_valid_ff || rsp_ready);
   assign sweep_last = (clr_idx_ff == CELL_W'(MAX_CELLS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_CLEAR:  if (sweep_last) state_in = SEQ_IDLE;
         SEQ_IDLE:   if (req_fire) state_in = SEQ_CALC;
         SEQ_CALC:   state_in = SEQ_LOOKUP;
         SEQ_LOOKUP: state_in = SEQ_DONE;
         SEQ_DONE: begin
            if (done_fire) begin
               state_in = (op_ff == OP_CLEAR) ? SEQ_CLEAR : SEQ_IDLE;
            end
         end
         default:    state_in = SEQ_IDLE;
      endcase
   end

   // response fields for the request in SEQ_DONE
   logic [1:0]         r_status;
   logic [CELL_W-1:0]  r_cell;
   logic [SLOT_W-1:0]  r_slot;
   logic [COUNT_W-1:0] r_count;
   logic [ENTRY_W-1:0] r_payload;
   logic               ins_store;

   always_comb begin
      r_status  = ST_OK;
      r_cell    = '0;
      r_slot    = '0;
      r_count   = '0;
      r_payload = '0;
      ins_store = 1'b0;
      case (op_ff)
         OP_INSERT: begin
            if (!calc_res.in_range) begin
               r_status = ST_OUT_RANGE;
            end else if (fill_rd_data >= COUNT_W'(SLOTS_PER_CELL)) begin
               r_status = ST_FULL;
               r_cell   = cell_ff;
               r_count  = fill_rd_data;
            end else begin
               ins_store = 1'b1;
               r_cell    = cell_ff;
               r_slot    = fill_rd_data[SLOT_W-1:0];
               r_count   = fill_rd_data + COUNT_W'(1);
            end
         end
         OP_READ: begin
            r_cell  = rd_cell_ff;
            r_slot  = rd_slot_ff;
            r_count = fill_rd_data;
            if ({1'b0, rd_slot_ff} < fill_rd_data) begin
               r_payload = ent_rd_data;
            end else begin
               r_status = ST_EMPTY;
            end
         end
         default: ;
      endcase
   end

   // memory and register controls
   always_comb begin
      calc_step    = (state_ff == SEQ_CALC);
      cell_in      = cell_ff;
      clr_idx_in   = clr_idx_ff;
      fill_rd_en   = 1'b0;
      fill_rd_addr = '0;
      ent_rd_en    = 1'b0;
      ent_rd_addr  = {rd_cell_ff, rd_slot_ff};
      fill_wr_en   = 1'b0;
      fill_wr_addr = cell_ff;
      fill_wr_data = '0;
      ent_wr_en    = 1'b0;
      ent_wr_addr  = {cell_ff, fill_rd_data[SLOT_W-1:0]};
      ent_wr_data  = {x_ff, y_ff, z_ff, sc_ff, id_ff};
      unique case (state_ff)
         SEQ_CLEAR: begin
            fill_wr_en   = 1'b1;
            fill_wr_addr = clr_idx_ff;
            clr_idx_in   = clr_idx_ff + CELL_W'(1);
         end
         SEQ_LOOKUP: begin
            cell_in      = (op_ff == OP_READ) ? rd_cell_ff : calc_res.cell_idx;
            fill_rd_en   = 1'b1;
            fill_rd_addr = cell_in;
            ent_rd_en    = (op_ff == OP_READ);
         end
         SEQ_DONE: begin
            if (done_fire) begin
               clr_idx_in = '0;
               if (ins_store) begin
                  fill_wr_en   = 1'b1;
                  fill_wr_data = r_count;
                  ent_wr_en    = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   // ---------------- response register ----------------
   logic [1:0]         rsp_status_ff;
   logic [CELL_W-1:0]  rsp_cell_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [ENTRY_W-1:0] rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_status_ff  <= r_status;
         rsp_cell_ff    <= r_cell;
         rsp_slot_ff    <= r_slot;
         rsp_count_ff   <= r_count;
         rsp_payload_ff <= r_payload;
      end
   end

   assign req_ready      = (state_ff == SEQ_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cell_res   = rsp_cell_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_cell_count = rsp_count_ff;
   assign rsp_out_x      = rsp_payload_ff[ENTRY_W-1 -: COORD_W];
   assign rsp_out_y      = rsp_payload_ff[ENTRY_W-1-COORD_W -: COORD_W];
   assign rsp_out_z      = rsp_payload_ff[ENTRY_W-1-2*COORD_W -: COORD_W];
   assign rsp_out_coord  = rsp_payload_ff[ID_W+COORD_W-1 -: COORD_W];
   assign rsp_out_id     = rsp_payload_ff[ID_W-1:0];

endmodule
